FILE: sv/bfpa_pkg.sv
package bfpa_pkg;

  localparam int NUM_CELLS = 16;
  localparam int IDX_W     = 4;
  localparam int SIZE_W    = 16;
  localparam int OWN_W     = 10;
  localparam int CNT_W     = 5;
  localparam int TOTAL_W   = 20;
  localparam int KIND_W    = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUM_CELLS);

  typedef enum logic [2:0] {
    ST_PLACED  = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_FREED   = 3'd2,
    ST_ALREADY = 3'd3,
    ST_LOADED  = 3'd4,
    ST_BAD     = 3'd5
  } status_t;

  typedef struct packed {
    logic                v;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    idx;
    logic [SIZE_W-1:0]   req;
    logic [OWN_W-1:0]    own;
    logic [CNT_W-1:0]    cnt;
    logic                found;
    logic [IDX_W-1:0]    best;
    logic [SIZE_W-1:0]   best_size;
    logic [TOTAL_W-1:0]  inner;
    logic [TOTAL_W-1:0]  outer;
    logic                freed;
    logic [OWN_W-1:0]    sown;
  } pkt_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  slot;
    logic [SIZE_W-1:0] used;
    logic [OWN_W-1:0]  owner;
  } commit_t;

endpackage

FILE: sv/bfpa_cell.sv
module bfpa_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [bfpa_pkg::IDX_W-1:0]      cell_idx,
  input  logic                            hold,
  input  bfpa_pkg::pkt_t                  pkt_in,
  input  bfpa_pkg::commit_t               commit,
  output bfpa_pkg::pkt_t                  pkt_out
);

  logic [bfpa_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [bfpa_pkg::SIZE_W-1:0] used_r, used_nxt;
  logic [bfpa_pkg::OWN_W-1:0]  owner_r, owner_nxt;
  logic                        busy_r, busy_nxt;
  bfpa_pkg::pkt_t              pkt_r, pkt_nxt;
  logic                        in_range;
  logic                        hit;
  logic [bfpa_pkg::SIZE_W-1:0] slack;

  assign in_range = {1'b0, cell_idx} < pkt_in.cnt;
  assign hit      = in_range && (pkt_in.idx == cell_idx);

  always_comb begin
    size_nxt  = size_r;
    used_nxt  = used_r;
    busy_nxt  = busy_r;
    owner_nxt = owner_r;
    pkt_nxt   = pkt_in;
    if (commit.en && commit.slot == cell_idx) begin
      busy_nxt  = 1'b1;
      used_nxt  = commit.used;
      owner_nxt = commit.owner;
    end
    if (pkt_in.v && hit) begin
      if (pkt_in.kind == bfpa_pkg::KIND_LOAD) begin
        size_nxt  = pkt_in.req;
        used_nxt  = '0;
        busy_nxt  = 1'b0;
        owner_nxt = '0;
      end else if (pkt_in.kind == bfpa_pkg::KIND_FREE && busy_r) begin
        pkt_nxt.freed = 1'b1;
        pkt_nxt.sown  = owner_r;
        used_nxt      = '0;
        busy_nxt      = 1'b0;
        owner_nxt     = '0;
      end
    end
    slack = size_nxt - used_nxt;
    if (pkt_in.v && in_range) begin
      if (busy_nxt) begin
        pkt_nxt.inner = pkt_in.inner +
                        {{(bfpa_pkg::TOTAL_W-bfpa_pkg::SIZE_W){1'b0}}, slack};
      end else begin
        pkt_nxt.outer = pkt_in.outer +
                        {{(bfpa_pkg::TOTAL_W-bfpa_pkg::SIZE_W){1'b0}}, size_nxt};
      end
      if (pkt_in.kind == bfpa_pkg::KIND_ALLOC && !busy_nxt && size_nxt >= pkt_in.req &&
          (!pkt_in.found || size_nxt < pkt_in.best_size)) begin
        pkt_nxt.found     = 1'b1;
        pkt_nxt.best      = cell_idx;
        pkt_nxt.best_size = size_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      used_r  <= '0;
      owner_r <= '0;
      pkt_r   <= '0;
    end else if (!hold) begin
      busy_r  <= busy_nxt;
      used_r  <= used_nxt;
      owner_r <= owner_nxt;
      pkt_r   <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      size_r <= size_nxt;
    end
  end

  assign pkt_out = pkt_r;

endmodule

FILE: sv/best_fit_partition_allocator_unit.sv
// Best-fit allocator over up to sixteen fixed partitions.
// Input channel in_*: in_tuser carries the kind (load, allocate, free),
// in_tdata the partition index, size and owner. Each transfer yields one
// result on out_*: out_tuser carries the status, out_tdata the slot, owner
// and the internal and external fragmentation totals after the item.
// cfg_wr_en/cfg_wr_data write the partition count; write it only while idle.
// Flow: an item passes through a chain of sixteen partition cells, each cell
// registering the item in turn while it holds one partition and folds its
// entry into the best fit and the totals; the last cell's output is then
// registered in the output register. One item is in flight at a time.
// A placement is written back to the chosen cell as the result leaves.
// The next item is taken once the result is in the output register, even
// while the receiver stalls; a stalled result holds the chain at its end.
// Reset (rst_n, synchronous) marks every partition free, clears the used sizes
// and owners, sets the count to zero and empties the chain and the output register.
module best_fit_partition_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,  // partition_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // part_index, request_size, owner_id, pad
  input  logic [1:0]  in_tuser,     // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,    // slot, slot_owner, internal_total, external_total, pad
  output logic [2:0]  out_tuser     // status
);

  localparam int N = bfpa_pkg::NUM_CELLS;

  logic [bfpa_pkg::CNT_W-1:0] cnt_r;
  logic [bfpa_pkg::CNT_W-1:0] cnt_eff;
  logic                       busy_r, busy_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [55:0]                out_data_r, out_data_nxt;
  bfpa_pkg::status_t          out_status_r, out_status_nxt;
  bfpa_pkg::pkt_t             head;
  bfpa_pkg::pkt_t             chain [N+1];
  bfpa_pkg::pkt_t             tail;
  bfpa_pkg::commit_t          commit;
  logic                       hold;
  logic                       finish;
  logic                       in_xfer;
  logic                       idx_ok;
  bfpa_pkg::status_t          status;
  logic [bfpa_pkg::IDX_W-1:0] slot;
  logic [bfpa_pkg::OWN_W-1:0] sown;
  logic [bfpa_pkg::TOTAL_W-1:0] inner_fin, outer_fin;
  logic [bfpa_pkg::TOTAL_W-1:0] best_ext, req_ext;

  assign cnt_eff   = (cnt_r > bfpa_pkg::CNT_MAX) ? bfpa_pkg::CNT_MAX : cnt_r;
  assign in_tready = !busy_r;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    head      = '0;
    head.v    = in_xfer;
    head.kind = in_tuser;
    head.idx  = in_tdata[3:0];
    head.req  = in_tdata[19:4];
    head.own  = in_tdata[29:20];
    head.cnt  = cnt_eff;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < N; g++) begin : g_cell
    bfpa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (bfpa_pkg::IDX_W'(g)),
      .hold     (hold),
      .pkt_in   (chain[g]),
      .commit   (commit),
      .pkt_out  (chain[g+1])
    );
  end

  assign tail   = chain[N];
  assign hold   = tail.v && out_valid_r && !out_tready;
  assign finish = tail.v && !hold;
  assign idx_ok = {1'b0, tail.idx} < tail.cnt;

  assign commit.en    = finish && tail.kind == bfpa_pkg::KIND_ALLOC && tail.found;
  assign commit.slot  = tail.best;
  assign commit.used  = tail.req;
  assign commit.owner = tail.own;

  assign best_ext = {{(bfpa_pkg::TOTAL_W-bfpa_pkg::SIZE_W){1'b0}}, tail.best_size};
  assign req_ext  = {{(bfpa_pkg::TOTAL_W-bfpa_pkg::SIZE_W){1'b0}}, tail.req};

  always_comb begin
    status    = bfpa_pkg::ST_BAD;
    slot      = '0;
    sown      = '0;
    inner_fin = tail.inner;
    outer_fin = tail.outer;
    unique case (tail.kind)
      bfpa_pkg::KIND_LOAD: begin
        if (idx_ok) begin
          status = bfpa_pkg::ST_LOADED;
          slot   = tail.idx;
        end
      end
      bfpa_pkg::KIND_ALLOC: begin
        if (tail.found) begin
          status    = bfpa_pkg::ST_PLACED;
          slot      = tail.best;
          sown      = tail.own;
          inner_fin = tail.inner + best_ext - req_ext;
          outer_fin = tail.outer - best_ext;
        end else begin
          status = bfpa_pkg::ST_NOFIT;
        end
      end
      bfpa_pkg::KIND_FREE: begin
        if (idx_ok) begin
          slot = tail.idx;
          if (tail.freed) begin
            status = bfpa_pkg::ST_FREED;
            sown   = tail.sown;
          end else begin
            status = bfpa_pkg::ST_ALREADY;
          end
        end
      end
      default: status = bfpa_pkg::ST_BAD;
    endcase
  end

  always_comb begin
    busy_nxt       = busy_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      busy_nxt       = 1'b0;
      out_valid_nxt  = 1'b1;
      out_data_nxt   = {2'b00, outer_fin, inner_fin, sown, slot};
      out_status_nxt = status;
    end
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cnt_r <= cfg_wr_data;
      end
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

FILE: sv/bfpa_checker.sv
module bfpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in flight");

  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bfpa_pkg::ST_BAD || out_tuser == bfpa_pkg::ST_NOFIT)
      |-> out_tdata[13:0] == '0)
    else $error("slot or owner set on failed item");

  a_no_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bfpa_pkg::ST_LOADED || out_tuser == bfpa_pkg::ST_ALREADY)
      |-> out_tdata[13:4] == '0)
    else $error("owner set on load or repeated free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not empty after reset");

endmodule

bind best_fit_partition_allocator_unit bfpa_checker u_bfpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
